// ----- hdl/sssb_pkg.sv -----
// Package for the swept segment support and bounds block.
// Coordinate, score and beat types, fill-level codes and the saturating half-step drop.
// No dependencies; every other file imports it.
package sssb_pkg;

  localparam int COORD_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_BITS   = 2 * COORD_BITS;
  localparam int SCORE_BITS  = PROD_BITS + 2;
  localparam int NUM_CORNERS = 4;
  localparam int IDX_BITS    = $clog2(NUM_CORNERS);
  localparam int PIPE_STAGES = 6;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_HALF = 2'd1;
  localparam logic [1:0] FILL_FULL = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SCORE_BITS-1:0] score_t;

  localparam coord_t COORD_HALF = coord_t'(1) <<< (FRAC_BITS - 1);
  localparam coord_t COORD_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic   mode;
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } in_item_t;

  typedef struct packed {
    coord_t support_x;
    coord_t support_y;
    coord_t support_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
    logic   is_empty;
  } out_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } dir_t;

  typedef struct packed {
    logic query;
    logic empty;
    logic full;
    logic dy_neg;
  } ctl_t;

  typedef struct {
    coord_t x  [NUM_CORNERS];
    coord_t y  [NUM_CORNERS];
    coord_t yd [NUM_CORNERS];
    coord_t z  [NUM_CORNERS];
  } corners_t;

  function automatic coord_t drop_half(coord_t v);
    logic [COORD_BITS:0] d;
    d = {v[COORD_BITS-1], v} - {1'b0, COORD_HALF};
    if (d[COORD_BITS] != d[COORD_BITS-1]) begin
      return COORD_MIN;
    end
    return coord_t'(d[COORD_BITS-1:0]);
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (b > a) ? b : a;
  endfunction

endpackage

// ----- hdl/sssb_if.sv -----
// Valid/ready channel interfaces for input and result beats.
// Depends on sssb_pkg for the beat types.
interface sssb_in_if import sssb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sssb_out_if import sssb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/sssb_store.sv -----
// Corner store: two pair slots, fill level and write slot, plus the snapshot register.
// Applies an add beat and registers the post-add corners, direction and control.
// Depends on sssb_pkg.
module sssb_store import sssb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     item_valid,
  input  in_item_t item,
  output corners_t snap,
  output dir_t     dir,
  output ctl_t     ctl
);

  coord_t cx [NUM_CORNERS];
  coord_t cy [NUM_CORNERS];
  coord_t cz [NUM_CORNERS];
  coord_t nx [NUM_CORNERS];
  coord_t ny [NUM_CORNERS];
  coord_t nz [NUM_CORNERS];
  logic [1:0] fill;
  logic [1:0] fill_next;
  logic       slot;
  logic       wr;

  always_comb begin
    logic [IDX_BITS-1:0] idx;
    wr = item_valid && (item.mode == MODE_ADD);
    fill_next = fill;
    if (wr && (fill != FILL_FULL)) begin
      fill_next = fill + 2'd1;
    end
    for (int i = 0; i < NUM_CORNERS; i++) begin
      idx = IDX_BITS'(i);
      nx[i] = cx[i];
      ny[i] = cy[i];
      nz[i] = cz[i];
      if (wr && (slot == idx[IDX_BITS-1])) begin
        nx[i] = idx[0] ? item.b_x : item.a_x;
        ny[i] = idx[0] ? item.b_y : item.a_y;
        nz[i] = idx[0] ? item.b_z : item.a_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= FILL_NONE;
      slot <= 1'b0;
    end else if (adv) begin
      fill <= fill_next;
      if (wr) begin
        slot <= ~slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        cx[i] <= nx[i];
        cy[i] <= ny[i];
        cz[i] <= nz[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        snap.x[i]  <= nx[i];
        snap.y[i]  <= ny[i];
        snap.yd[i] <= drop_half(ny[i]);
        snap.z[i]  <= nz[i];
      end
      dir.x      <= item.dir_x;
      dir.y      <= item.dir_y;
      dir.z      <= item.dir_z;
      ctl.query  <= (item.mode == MODE_QUERY);
      ctl.empty  <= (fill_next == FILL_NONE);
      ctl.full   <= (fill_next == FILL_FULL);
      ctl.dy_neg <= item.dir_y[COORD_BITS-1];
    end
  end

endmodule

// ----- hdl/sssb_support.sv -----
// Support point path: products, dot-product sums, pairwise and final best-corner pick.
// Four stages from the snapshot register to the support fields of the result register.
// Depends on sssb_pkg.
module sssb_support import sssb_pkg::*; (
  input  logic     clk,
  input  logic     adv,
  input  corners_t snap,
  input  dir_t     dir,
  input  ctl_t     ctl5,
  output coord_t   sup_x,
  output coord_t   sup_y,
  output coord_t   sup_z
);

  prod_t    px [NUM_CORNERS];
  prod_t    py [NUM_CORNERS];
  prod_t    pz [NUM_CORNERS];
  score_t   s  [NUM_CORNERS];
  corners_t c3;
  corners_t c4;
  corners_t c5;
  score_t   s01;
  score_t   s23;
  logic     w01;
  logic     w23;
  logic     pick_hi;
  logic [IDX_BITS-1:0] best;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        px[i] <= prod_t'(snap.x[i]) * prod_t'(dir.x);
        py[i] <= prod_t'(snap.y[i]) * prod_t'(dir.y);
        pz[i] <= prod_t'(snap.z[i]) * prod_t'(dir.z);
      end
      c3 <= snap;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        s[i] <= score_t'(px[i]) + score_t'(py[i]) + score_t'(pz[i]);
      end
      c4 <= c3;
    end
  end

  // ties keep the lower corner
  always_ff @(posedge clk) begin
    if (adv) begin
      w01 <= (s[1] > s[0]);
      s01 <= (s[1] > s[0]) ? s[1] : s[0];
      w23 <= (s[3] > s[2]);
      s23 <= (s[3] > s[2]) ? s[3] : s[2];
      c5  <= c4;
    end
  end

  always_comb begin
    pick_hi = ctl5.full && (s23 > s01);
    best    = pick_hi ? {1'b1, w23} : {1'b0, w01};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl5.query && !ctl5.empty) begin
        sup_x <= c5.x[best];
        sup_y <= ctl5.dy_neg ? c5.yd[best] : c5.y[best];
        sup_z <= c5.z[best];
      end else begin
        sup_x <= '0;
        sup_y <= '0;
        sup_z <= '0;
      end
    end
  end

endmodule

// ----- hdl/sssb_bounds.sv -----
// Bounding box path: per-pair extents, two delay stages, final merge into the result register.
// Min y uses the half-dropped corner y values.
// Depends on sssb_pkg.
module sssb_bounds import sssb_pkg::*; (
  input  logic     clk,
  input  logic     adv,
  input  corners_t snap,
  input  ctl_t     ctl5,
  output coord_t   box_min_x,
  output coord_t   box_min_y,
  output coord_t   box_min_z,
  output coord_t   box_max_x,
  output coord_t   box_max_y,
  output coord_t   box_max_z
);

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } ext_t;

  ext_t e01_3;
  ext_t e23_3;
  ext_t e01_4;
  ext_t e23_4;
  ext_t e01_5;
  ext_t e23_5;

  always_ff @(posedge clk) begin
    if (adv) begin
      e01_3.lo_x <= cmin(snap.x[0], snap.x[1]);
      e01_3.lo_y <= cmin(snap.yd[0], snap.yd[1]);
      e01_3.lo_z <= cmin(snap.z[0], snap.z[1]);
      e01_3.hi_x <= cmax(snap.x[0], snap.x[1]);
      e01_3.hi_y <= cmax(snap.y[0], snap.y[1]);
      e01_3.hi_z <= cmax(snap.z[0], snap.z[1]);
      e23_3.lo_x <= cmin(snap.x[2], snap.x[3]);
      e23_3.lo_y <= cmin(snap.yd[2], snap.yd[3]);
      e23_3.lo_z <= cmin(snap.z[2], snap.z[3]);
      e23_3.hi_x <= cmax(snap.x[2], snap.x[3]);
      e23_3.hi_y <= cmax(snap.y[2], snap.y[3]);
      e23_3.hi_z <= cmax(snap.z[2], snap.z[3]);
      e01_4 <= e01_3;
      e23_4 <= e23_3;
      e01_5 <= e01_4;
      e23_5 <= e23_4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl5.empty) begin
        box_min_x <= '0;
        box_min_y <= '0;
        box_min_z <= '0;
        box_max_x <= '0;
        box_max_y <= '0;
        box_max_z <= '0;
      end else if (ctl5.full) begin
        box_min_x <= cmin(e01_5.lo_x, e23_5.lo_x);
        box_min_y <= cmin(e01_5.lo_y, e23_5.lo_y);
        box_min_z <= cmin(e01_5.lo_z, e23_5.lo_z);
        box_max_x <= cmax(e01_5.hi_x, e23_5.hi_x);
        box_max_y <= cmax(e01_5.hi_y, e23_5.hi_y);
        box_max_z <= cmax(e01_5.hi_z, e23_5.hi_z);
      end else begin
        box_min_x <= e01_5.lo_x;
        box_min_y <= e01_5.lo_y;
        box_min_z <= e01_5.lo_z;
        box_max_x <= e01_5.hi_x;
        box_max_y <= e01_5.hi_y;
        box_max_z <= e01_5.hi_z;
      end
    end
  end

endmodule

// ----- hdl/swept_segment_support_and_bounds.sv -----
// Top level of the swept segment support and bounds block.
// Depends on sssb_pkg, sssb_if, sssb_store, sssb_support and sssb_bounds.
//
//   port     dir   beat        carries
//   in_ch    sink  in_item_t   mode, corner pair a/b, query direction
//   out_ch   src   out_item_t  support point, bounding box, is_empty
//
// One beat in per cycle while the result is not stalled, one result per beat; six register
// stages, the last of which holds the offered result.
// Stages: input register, store update and snapshot, products, sums, pair pick, result.
// The corner store is updated as a beat leaves the input register, so queries see prior adds.
// A stalled result freezes the whole pipe; in_ch.ready is low only then.
// Reset clears the fill level, write slot and stage valids.
module swept_segment_support_and_bounds import sssb_pkg::*; (
  input logic       clk,
  input logic       rst,
  sssb_in_if.sink   in_ch,
  sssb_out_if.source out_ch
);

  logic [PIPE_STAGES-1:0] vld;
  logic     adv;
  in_item_t item1;
  corners_t snap;
  dir_t     dir;
  ctl_t     ctl2;
  ctl_t     ctl3;
  ctl_t     ctl4;
  ctl_t     ctl5;
  logic     empty6;
  coord_t   sup_x;
  coord_t   sup_y;
  coord_t   sup_z;
  coord_t   box_min_x;
  coord_t   box_min_y;
  coord_t   box_min_z;
  coord_t   box_max_x;
  coord_t   box_max_y;
  coord_t   box_max_z;

  assign adv          = !vld[PIPE_STAGES-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_STAGES-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item1  <= in_ch.data;
      ctl3   <= ctl2;
      ctl4   <= ctl3;
      ctl5   <= ctl4;
      empty6 <= ctl5.empty;
    end
  end

  sssb_store u_store (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (vld[0]),
    .item       (item1),
    .snap       (snap),
    .dir        (dir),
    .ctl        (ctl2)
  );

  sssb_support u_support (
    .clk   (clk),
    .adv   (adv),
    .snap  (snap),
    .dir   (dir),
    .ctl5  (ctl5),
    .sup_x (sup_x),
    .sup_y (sup_y),
    .sup_z (sup_z)
  );

  sssb_bounds u_bounds (
    .clk       (clk),
    .adv       (adv),
    .snap      (snap),
    .ctl5      (ctl5),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_min_z (box_min_z),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y),
    .box_max_z (box_max_z)
  );

  always_comb begin
    out_ch.data.support_x = sup_x;
    out_ch.data.support_y = sup_y;
    out_ch.data.support_z = sup_z;
    out_ch.data.box_min_x = box_min_x;
    out_ch.data.box_min_y = box_min_y;
    out_ch.data.box_min_z = box_min_z;
    out_ch.data.box_max_x = box_max_x;
    out_ch.data.box_max_y = box_max_y;
    out_ch.data.box_max_z = box_max_z;
    out_ch.data.is_empty  = empty6;
  end

endmodule

// ----- hdl/sssb_checker.sv -----
// Port-level checker for swept_segment_support_and_bounds, with its bind.
// Depends on sssb_pkg.
module sssb_checker import sssb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_empty |->
      out_data.support_x == 0 && out_data.support_y == 0 && out_data.support_z == 0 &&
      out_data.box_min_x == 0 && out_data.box_min_y == 0 && out_data.box_min_z == 0 &&
      out_data.box_max_x == 0 && out_data.box_max_y == 0 && out_data.box_max_z == 0)
    else $error("empty result carries nonzero fields");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_empty |->
      out_data.box_min_x <= out_data.box_max_x &&
      out_data.box_min_y <= out_data.box_max_y &&
      out_data.box_min_z <= out_data.box_max_z)
    else $error("box min exceeds box max");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind swept_segment_support_and_bounds sssb_checker u_sssb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
